>>> design/aabb_clip_space_cull_assert.svh
// ----------------------------------------------------------------------------
// aabb_clip_space_cull assertion macros
// Concurrent assertion shorthands for the box cull checker.
// ----------------------------------------------------------------------------
`ifndef AABB_CLIP_SPACE_CULL_ASSERT_SVH
`define AABB_CLIP_SPACE_CULL_ASSERT_SVH

// antecedent implies consequent in the same cycle, outside reset
`define ACS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle, outside reset
`define ACS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle, reset included
`define ACS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg
// Shared widths, types and codes of the clip-space box cull block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acs_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_W      = 2 * DATA_WIDTH;
    localparam int ACC_W       = PROD_W + 5;
    localparam int NUM_AXES    = 3;
    localparam int NUM_LANES   = 3;
    localparam int NUM_COLS    = 4;
    localparam int NUM_ROWS    = 4;
    localparam int NUM_CORNERS = 8;
    localparam int ROW_IDX_W   = 2;
    localparam int CFG_IDX_W   = 1;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [ACC_W-1:0]      t_acc;

    localparam t_data NEAR_RESET = DATA_WIDTH'(6554);
    localparam t_data FAR_RESET  = DATA_WIDTH'(65536000);

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TEST = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR = 1'b0,
        CFG_FAR  = 1'b1
    } t_cfg_index;

    localparam logic [ROW_IDX_W-1:0] ROW_X = 2'd0;
    localparam logic [ROW_IDX_W-1:0] ROW_Y = 2'd1;
    localparam logic [ROW_IDX_W-1:0] ROW_W = 2'd3;

    typedef struct packed {
        t_acc x;
        t_acc y;
        t_acc w;
    } t_corner;

    typedef struct packed {
        logic outside_x;
        logic outside_y;
        logic outside_depth;
    } t_cull_flags;

endpackage

>>> design/acs_corner_test.sv
// ----------------------------------------------------------------------------
// acs_corner_test
// Clip tests of the eight transformed corners and reduction to cull flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acs_corner_test (
    input  acs_pkg::t_corner     i_corners [acs_pkg::NUM_CORNERS],
    input  acs_pkg::t_data       i_near,
    input  acs_pkg::t_data       i_far,
    output acs_pkg::t_cull_flags o_flags
);
    import acs_pkg::*;

    t_acc                   zn;
    t_acc                   zf;
    logic [NUM_CORNERS-1:0] in_x;
    logic [NUM_CORNERS-1:0] in_y;
    logic [NUM_CORNERS-1:0] in_d;

    always_comb begin
        zn = ACC_W'(i_near) <<< FRAC_BITS;
        zf = ACC_W'(i_far) <<< FRAC_BITS;
        for (int c = 0; c < NUM_CORNERS; c++) begin
            in_x[c] = ((i_corners[c].x + i_corners[c].w) >= 0)
                   && ((i_corners[c].w - i_corners[c].x) >= 0);
            in_y[c] = ((i_corners[c].y + i_corners[c].w) >= 0)
                   && ((i_corners[c].w - i_corners[c].y) >= 0);
            in_d[c] = ((i_corners[c].w - zn) >= 0)
                   && ((zf - i_corners[c].w) >= 0);
        end
        o_flags.outside_x     = ~|in_x;
        o_flags.outside_y     = ~|in_y;
        o_flags.outside_depth = ~|in_d;
    end

endmodule

>>> design/aabb_clip_space_cull.sv
// ----------------------------------------------------------------------------
// aabb_clip_space_cull
// Clip-space visibility test of axis-aligned boxes against a 4x4 matrix.
// ----------------------------------------------------------------------------
// One item is taken per cycle while o_ready is high. A load item writes one
// matrix row at its transfer and gives no result; a test item gives one
// result from the output register of the last stage. The four stages are:
// eighteen parallel 32x32 products of the matrix with the box center and
// half extents, a base sum per row with the signed half-extent sums of each
// corner, the eight corner coordinates, and the clip compares into the
// output register. Each stage holds only while the stage after it is full
// and stalled, so bubbles close up. After reset the matrix is all zero and
// the depth bounds are 6554 and 65536000 (Q16.16).
`timescale 1ns / 1ps

module aabb_clip_space_cull (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [acs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [acs_pkg::DATA_WIDTH-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_kind,
    input  logic [acs_pkg::ROW_IDX_W-1:0]   i_row_index,
    input  acs_pkg::t_data                  i_m_col0,
    input  acs_pkg::t_data                  i_m_col1,
    input  acs_pkg::t_data                  i_m_col2,
    input  acs_pkg::t_data                  i_m_col3,
    input  acs_pkg::t_data                  i_center_x,
    input  acs_pkg::t_data                  i_center_y,
    input  acs_pkg::t_data                  i_center_z,
    input  acs_pkg::t_data                  i_half_x,
    input  acs_pkg::t_data                  i_half_y,
    input  acs_pkg::t_data                  i_half_z,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_visible,
    output logic                            o_empty_box,
    output logic                            o_outside_x,
    output logic                            o_outside_y,
    output logic                            o_outside_depth
);
    import acs_pkg::*;

    localparam logic [ROW_IDX_W-1:0] LANE_ROW [NUM_LANES] = '{ROW_X, ROW_Y, ROW_W};

    t_data       r_matrix [NUM_ROWS][NUM_COLS];
    t_data       r_near;
    t_data       r_far;

    t_data       center [NUM_AXES];
    t_data       half   [NUM_AXES];

    logic        r_v1;
    logic        r_e1;
    t_prod       r_prod_c [NUM_LANES][NUM_AXES];
    t_prod       r_prod_h [NUM_LANES][NUM_AXES];
    t_data       r_trans  [NUM_LANES];
    t_prod       n_prod_c [NUM_LANES][NUM_AXES];
    t_prod       n_prod_h [NUM_LANES][NUM_AXES];

    logic        r_v2;
    logic        r_e2;
    t_acc        r_base  [NUM_LANES];
    t_acc        r_delta [NUM_CORNERS][NUM_LANES];
    t_acc        n_base  [NUM_LANES];
    t_acc        n_delta [NUM_CORNERS][NUM_LANES];

    logic        r_v3;
    logic        r_e3;
    t_corner     r_corner [NUM_CORNERS];
    t_corner     n_corner [NUM_CORNERS];

    logic        r_out_valid;
    logic        r_visible;
    logic        r_empty;
    t_cull_flags r_flags;
    t_cull_flags test_flags;

    logic        rdy1;
    logic        rdy2;
    logic        rdy3;
    logic        rdy_o;
    logic        in_xfer;
    logic        test_xfer;
    logic        load_xfer;
    logic        empty_in;

    assign center = '{i_center_x, i_center_y, i_center_z};
    assign half   = '{i_half_x, i_half_y, i_half_z};

    assign rdy_o     = !r_out_valid || i_ready;
    assign rdy3      = !r_v3 || rdy_o;
    assign rdy2      = !r_v2 || rdy3;
    assign rdy1      = !r_v1 || rdy2;
    assign o_ready   = rdy1;
    assign in_xfer   = i_valid && rdy1;
    assign test_xfer = in_xfer && (i_kind == KIND_TEST);
    assign load_xfer = in_xfer && (i_kind == KIND_LOAD);
    assign empty_in  = (i_half_x == '0) && (i_half_y == '0) && (i_half_z == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= NEAR_RESET;
            r_far  <= FAR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NEAR: r_near <= i_cfg_data;
                CFG_FAR:  r_far  <= i_cfg_data;
                default:  r_near <= r_near;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                for (int k = 0; k < NUM_COLS; k++) begin
                    r_matrix[r][k] <= '0;
                end
            end
        end else if (load_xfer) begin
            r_matrix[i_row_index] <= '{i_m_col0, i_m_col1, i_m_col2, i_m_col3};
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_LANES; r++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                n_prod_c[r][k] = PROD_W'(r_matrix[LANE_ROW[r]][k]) * PROD_W'(center[k]);
                n_prod_h[r][k] = PROD_W'(r_matrix[LANE_ROW[r]][k]) * PROD_W'(half[k]);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_LANES; r++) begin
            n_base[r] = (ACC_W'(r_trans[r]) <<< FRAC_BITS)
                      + ACC_W'(r_prod_c[r][0]) + ACC_W'(r_prod_c[r][1])
                      + ACC_W'(r_prod_c[r][2]);
        end
        for (int c = 0; c < NUM_CORNERS; c++) begin
            for (int r = 0; r < NUM_LANES; r++) begin
                n_delta[c][r] = '0;
                for (int k = 0; k < NUM_AXES; k++) begin
                    if (((c >> k) & 1) != 0) begin
                        n_delta[c][r] = n_delta[c][r] - ACC_W'(r_prod_h[r][k]);
                    end else begin
                        n_delta[c][r] = n_delta[c][r] + ACC_W'(r_prod_h[r][k]);
                    end
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CORNERS; c++) begin
            n_corner[c].x = r_base[0] + r_delta[c][0];
            n_corner[c].y = r_base[1] + r_delta[c][1];
            n_corner[c].w = r_base[2] + r_delta[c][2];
        end
    end

    acs_corner_test u_corner_test (
        .i_corners (r_corner),
        .i_near    (r_near),
        .i_far     (r_far),
        .o_flags   (test_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= test_xfer;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy_o) begin
                r_out_valid <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (test_xfer) begin
            r_e1     <= empty_in;
            r_prod_c <= n_prod_c;
            r_prod_h <= n_prod_h;
            for (int r = 0; r < NUM_LANES; r++) begin
                r_trans[r] <= r_matrix[LANE_ROW[r]][NUM_COLS-1];
            end
        end
        if (rdy2 && r_v1) begin
            r_e2    <= r_e1;
            r_base  <= n_base;
            r_delta <= n_delta;
        end
        if (rdy3 && r_v2) begin
            r_e3     <= r_e2;
            r_corner <= n_corner;
        end
        if (rdy_o && r_v3) begin
            r_empty <= r_e3;
            if (r_e3) begin
                r_visible <= 1'b1;
                r_flags   <= '0;
            end else begin
                r_visible <= !(test_flags.outside_x && test_flags.outside_y
                               && test_flags.outside_depth);
                r_flags   <= test_flags;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_visible       = r_visible;
    assign o_empty_box     = r_empty;
    assign o_outside_x     = r_flags.outside_x;
    assign o_outside_y     = r_flags.outside_y;
    assign o_outside_depth = r_flags.outside_depth;

endmodule

>>> design/acs_checker.sv
// ----------------------------------------------------------------------------
// acs_checker
// Port-level checks of the box cull block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "aabb_clip_space_cull_assert.svh"

module acs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_visible,
    input logic i_empty_box,
    input logic i_outside_x,
    input logic i_outside_y,
    input logic i_outside_depth
);

    `ACS_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !i_out_valid, "result valid after reset")

    `ACS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_visible, i_empty_box, i_outside_x, i_outside_y, i_outside_depth}), "stalled result changed")

    `ACS_ASSERT_IMPL(a_empty_visible, i_clk, i_rst_n, i_out_valid && i_empty_box, i_visible && !i_outside_x && !i_outside_y && !i_outside_depth, "empty box not plainly visible")

    `ACS_ASSERT_IMPL(a_cull_all_out, i_clk, i_rst_n, i_out_valid && !i_visible, i_outside_x && i_outside_y && i_outside_depth && !i_empty_box, "culled box with a passing test")

endmodule

bind aabb_clip_space_cull acs_checker u_acs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_valid),
    .i_out_ready     (i_ready),
    .i_visible       (o_visible),
    .i_empty_box     (o_empty_box),
    .i_outside_x     (o_outside_x),
    .i_outside_y     (o_outside_y),
    .i_outside_depth (o_outside_depth)
);
